// ===== hw/rtl/hsv_pkg.sv =====
package hsv_pkg;

  localparam logic [8:0] HUE_MAX = 9'd359;
  localparam logic [6:0] PCT_MAX = 7'd100;

  localparam int LVL_W = 20;
  localparam int PROD_W = 41;
  localparam int SCALE_SHIFT = 32;

  // 255/600000 scaled by 2^32, rounded down; the bias absorbs the shortfall on
  // exact multiples and stays below the smallest nonzero fraction step
  localparam logic [20:0] SCALE_K = 21'd1825361;
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(65536);

  localparam logic [LVL_W-1:0] SIXTY = LVL_W'(60);
  localparam logic [LVL_W-1:0] FULL_CHROMA = LVL_W'(6000);
  localparam logic [5:0] SECTOR_SPAN = 6'd60;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW  = 3'd0,
    SEC_YELLOW_GRN  = 3'd1,
    SEC_GRN_CYAN    = 3'd2,
    SEC_CYAN_BLUE   = 3'd3,
    SEC_BLUE_MAG    = 3'd4,
    SEC_MAG_RED     = 3'd5
  } sector_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  function automatic sector_t hue_sector(input logic [8:0] h);
    sector_t s;
    if (h >= 9'd300) s = SEC_MAG_RED;
    else if (h >= 9'd240) s = SEC_BLUE_MAG;
    else if (h >= 9'd180) s = SEC_CYAN_BLUE;
    else if (h >= 9'd120) s = SEC_GRN_CYAN;
    else if (h >= 9'd60) s = SEC_YELLOW_GRN;
    else s = SEC_RED_YELLOW;
    return s;
  endfunction

  function automatic logic [8:0] sector_base(input sector_t s);
    logic [8:0] b;
    unique case (s)
      SEC_RED_YELLOW: b = 9'd0;
      SEC_YELLOW_GRN: b = 9'd60;
      SEC_GRN_CYAN:   b = 9'd120;
      SEC_CYAN_BLUE:  b = 9'd180;
      SEC_BLUE_MAG:   b = 9'd240;
      SEC_MAG_RED:    b = 9'd300;
      default:        b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/hsv_ifs.sv =====
interface hsv_if import hsv_pkg::*; ();
  logic     valid;
  logic     ready;
  hsv_pix_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rgb_if import hsv_pkg::*; ();
  logic     valid;
  logic     ready;
  rgb_pix_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/hsv_scale.sv =====
module hsv_scale import hsv_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [LVL_W-1:0] num,
  output logic [7:0]       lvl
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] biased;

  assign prod_nxt = PROD_W'(num) * PROD_W'(SCALE_K);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // floor(num*255/600000) without a divider
  assign biased = prod_r + ROUND_BIAS;
  assign lvl = biased[SCALE_SHIFT +: 8];

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// hsv to rgb converter, five register stages
// a word moves through stages 0 to 4 in order; output valid is the stage 4 valid bit
// throughput: one word per cycle while the sink is ready; each stage holds its word while the next is full
// the product and reciprocal-scale multipliers set the stage split
// reset (synchronous, rst_n low) clears the stage valid bits only
module hsv_to_rgb_converter_top import hsv_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  hsv_if.sink     in_hsv,
  rgb_if.source   out_rgb
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_rgb.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = rdy[0] ? in_hsv.valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = v_r[i-1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_hsv.ready = rdy[0];

  // stage 0: clamp, sector and ramp position
  logic [8:0] hs;
  logic [6:0] ss;
  logic [6:0] vs;
  sector_t    sec;
  logic [8:0] off;
  logic [5:0] f;

  always_comb begin
    hs  = (in_hsv.data.hue > HUE_MAX) ? HUE_MAX : in_hsv.data.hue;
    ss  = (in_hsv.data.saturation > PCT_MAX) ? PCT_MAX : in_hsv.data.saturation;
    vs  = (in_hsv.data.brightness > PCT_MAX) ? PCT_MAX : in_hsv.data.brightness;
    sec = hue_sector(hs);
    off = hs - sector_base(sec);
    // falling ramp in odd sectors
    f   = sec[0] ? (SECTOR_SPAN - off[5:0]) : off[5:0];
  end

  logic [6:0] s0_r;
  logic [6:0] v0_r;
  logic [5:0] f0_r;
  sector_t    sec0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_r   <= ss;
      v0_r   <= vs;
      f0_r   <= f;
      sec0_r <= sec;
    end
  end

  // stage 1: s*v and v*(100-s)
  logic [13:0] sv_nxt;
  logic [13:0] vm_nxt;
  logic [13:0] sv1_r;
  logic [13:0] vm1_r;
  logic [6:0]  v1_r;
  logic [5:0]  f1_r;
  sector_t     sec1_r;

  assign sv_nxt = 14'(s0_r) * 14'(v0_r);
  assign vm_nxt = 14'(v0_r) * 14'(PCT_MAX - s0_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sv1_r  <= sv_nxt;
      vm1_r  <= vm_nxt;
      v1_r   <= v0_r;
      f1_r   <= f0_r;
      sec1_r <= sec0_r;
    end
  end

  // stage 2: level numerators over 600000
  logic [LVL_W-1:0] x_nxt;
  logic [LVL_W-1:0] m_nxt;
  logic [LVL_W-1:0] cm_nxt;
  logic [LVL_W-1:0] x2_r;
  logic [LVL_W-1:0] m2_r;
  logic [LVL_W-1:0] cm2_r;
  sector_t          sec2_r;

  assign x_nxt  = LVL_W'(sv1_r) * LVL_W'(f1_r);
  assign m_nxt  = LVL_W'(vm1_r) * SIXTY;
  // c + m collapses to 6000*v
  assign cm_nxt = LVL_W'(v1_r) * FULL_CHROMA;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x2_r   <= x_nxt + m_nxt;
      m2_r   <= m_nxt;
      cm2_r  <= cm_nxt;
      sec2_r <= sec1_r;
    end
  end

  // stage 3: scale to bytes
  logic [7:0] lvl_c;
  logic [7:0] lvl_x;
  logic [7:0] lvl_0;
  sector_t    sec3_r;

  hsv_scale u_scale_c (.clk(clk), .en(rdy[3]), .num(cm2_r), .lvl(lvl_c));
  hsv_scale u_scale_x (.clk(clk), .en(rdy[3]), .num(x2_r),  .lvl(lvl_x));
  hsv_scale u_scale_0 (.clk(clk), .en(rdy[3]), .num(m2_r),  .lvl(lvl_0));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sec3_r <= sec2_r;
    end
  end

  // stage 4: place levels on channels
  rgb_pix_t rgb_nxt;
  rgb_pix_t rgb_r;

  always_comb begin
    unique case (sec3_r)
      SEC_RED_YELLOW: rgb_nxt = '{red: lvl_c, green: lvl_x, blue: lvl_0};
      SEC_YELLOW_GRN: rgb_nxt = '{red: lvl_x, green: lvl_c, blue: lvl_0};
      SEC_GRN_CYAN:   rgb_nxt = '{red: lvl_0, green: lvl_c, blue: lvl_x};
      SEC_CYAN_BLUE:  rgb_nxt = '{red: lvl_0, green: lvl_x, blue: lvl_c};
      SEC_BLUE_MAG:   rgb_nxt = '{red: lvl_x, green: lvl_0, blue: lvl_c};
      SEC_MAG_RED:    rgb_nxt = '{red: lvl_c, green: lvl_0, blue: lvl_x};
      default:        rgb_nxt = '{red: lvl_c, green: lvl_0, blue: lvl_x};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_rgb.valid = v_r[NSTG-1];
  assign out_rgb.data  = rgb_r;

  // a bubble anywhere in the pipe must let a new word in
  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_hsv.ready)
    else $error("input stalled with an empty stage");

  // chroma level bounds the ramp level, which bounds the floor level
  a_lvl_order: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (lvl_c >= lvl_x) && (lvl_x >= lvl_0))
    else $error("channel levels out of order");

  // output valid only rises after the scale stage held a word
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rgb.valid) |-> $past(v_r[3]))
    else $error("output valid without a word in the scale stage");

  // numerators keep c+m >= x+m >= m
  a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (x2_r <= cm2_r) && (m2_r <= x2_r))
    else $error("level numerators out of order");

endmodule

// ===== dv/hsv_rgb_checker.sv =====
module hsv_rgb_checker import hsv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hsv_if       in_mon,
  rgb_if       out_mon,
  output int   n_fail,
  output int   n_pending,
  output int   n_checked
);

  localparam longint unsigned FULL_SCALE = 255;
  // every channel level is held over this common denominator (10000 * 60)
  localparam longint unsigned LVL_DENOM  = 600000;
  localparam longint unsigned HUE_PERIOD = 120;
  localparam longint unsigned HUE_SPAN   = 60;

  rgb_pix_t rgb_due[$];
  int       fail_cnt = 0;
  int       check_cnt = 0;
  int       pend_cnt = 0;

  function automatic logic [7:0] level_to_byte(input longint unsigned lvl);
    return 8'((lvl * FULL_SCALE) / LVL_DENOM);
  endfunction

  function automatic rgb_pix_t rgb_from_hsv(input hsv_pix_t pix);
    logic [8:0]      h;
    longint unsigned s, v, hm, f, m;
    logic [7:0]      lc, lx, l0;
    rgb_pix_t        rgb;
    h = (pix.hue > HUE_MAX) ? HUE_MAX : pix.hue;
    s = (pix.saturation > PCT_MAX) ? PCT_MAX : pix.saturation;
    v = (pix.brightness > PCT_MAX) ? PCT_MAX : pix.brightness;
    hm = h % HUE_PERIOD;
    // distance from the nearest sector edge pair, 60 - |hm - 60|
    f = (hm >= HUE_SPAN) ? (HUE_PERIOD - hm) : hm;
    m = HUE_SPAN * v * (PCT_MAX - s);
    lc = level_to_byte(HUE_SPAN * s * v + m);
    lx = level_to_byte(s * v * f + m);
    l0 = level_to_byte(m);
    case (sector_t'(3'(h / 9'd60)))
      SEC_RED_YELLOW: rgb = '{lc, lx, l0};
      SEC_YELLOW_GRN: rgb = '{lx, lc, l0};
      SEC_GRN_CYAN:   rgb = '{l0, lc, lx};
      SEC_CYAN_BLUE:  rgb = '{l0, lx, lc};
      SEC_BLUE_MAG:   rgb = '{lx, l0, lc};
      default:        rgb = '{lc, l0, lx};
    endcase
    return rgb;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    rgb_pix_t due;
    if (rst_n) begin
      // retire before enqueue: a word accepted now cannot leave in the same cycle
      if (out_mon.valid && out_mon.ready) begin
        if (rgb_due.size() == 0) begin
          $error("rgb word %h arrived with no pixel pending", out_mon.data);
          fail_cnt++;
        end else begin
          due = rgb_due.pop_front();
          check_cnt++;
          compare_field("red", due.red, out_mon.data.red);
          compare_field("green", due.green, out_mon.data.green);
          compare_field("blue", due.blue, out_mon.data.blue);
        end
      end
      if (in_mon.valid && in_mon.ready)
        rgb_due.insert(rgb_due.size(), rgb_from_hsv(in_mon.data));
      pend_cnt = rgb_due.size();
    end
  end

  assign n_fail    = fail_cnt;
  assign n_pending = pend_cnt;
  assign n_checked = check_cnt;

endmodule

// ===== dv/testbench.sv =====
module testbench import hsv_pkg::*; ();

  localparam int N_RANDOM = 550;

  logic clk;
  logic rst_n;
  logic calm;
  int   n_fail, n_pending, n_checked;

  hsv_if in_hsv();
  rgb_if out_rgb();

  hsv_to_rgb_converter_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_hsv  (in_hsv),
    .out_rgb (out_rgb)
  );

  hsv_rgb_checker i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_hsv),
    .out_mon   (out_rgb),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink drops ready with a chance of about one in five unless in a calm stretch
  always @(posedge clk) begin
    out_rgb.ready <= calm || ($urandom_range(99) >= 20);
  end

  // ready is looked at mid-cycle, where it is settled for the coming edge
  task automatic push_word(input hsv_pix_t w);
    logic taken;
    in_hsv.valid <= 1'b1;
    in_hsv.data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_hsv.ready;
      @(posedge clk);
    end
    if (!calm) begin
      while ($urandom_range(99) < 20) begin
        in_hsv.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic push_hsv(input int h, input int s, input int v);
    hsv_pix_t w;
    w.hue        = 9'(h);
    w.saturation = 7'(s);
    w.brightness = 7'(v);
    push_word(w);
  endtask

  task automatic drain();
    in_hsv.valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    @(posedge clk);
  endtask

  function automatic hsv_pix_t rand_pixel();
    hsv_pix_t p;
    p.hue        = 9'($urandom_range(359));
    p.saturation = 7'($urandom_range(100));
    p.brightness = 7'($urandom_range(100));
    case ($urandom_range(9))
      0: p = hsv_pix_t'(23'($urandom));
      1: p.hue = 9'(60 * $urandom_range(1, 5) - 1 + $urandom_range(2));
      2: p.saturation = $urandom_range(1) ? 7'd0 : PCT_MAX;
      3: p.brightness = $urandom_range(1) ? 7'd0 : PCT_MAX;
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    rst_n         <= 1'b0;
    calm          <= 1'b1;
    in_hsv.valid  <= 1'b0;
    in_hsv.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    calm <= 1'b0;

    // corners of the fields and of the hue circle
    push_hsv(0, 0, 0);
    push_hsv(359, 100, 100);
    push_hsv(511, 127, 127);
    push_hsv(360, 101, 101);
    push_hsv(0, 100, 100);
    push_hsv(60, 100, 100);
    push_hsv(120, 100, 100);
    push_hsv(180, 100, 100);
    push_hsv(240, 100, 100);
    push_hsv(300, 100, 100);
    push_hsv(59, 100, 100);
    push_hsv(119, 100, 100);
    push_hsv(299, 100, 100);
    push_hsv(90, 100, 50);
    push_hsv(30, 50, 75);
    push_hsv(210, 0, 100);
    push_hsv(45, 0, 37);
    push_hsv(330, 100, 1);
    push_hsv(150, 1, 100);
    push_hsv(270, 127, 0);
    push_hsv(256, 64, 64);
    push_hsv(170, 27, 99);

    // sender holds off until the pipeline is empty
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      calm <= (i >= 100 && i < 250);
      if (i == 400) drain();
      push_word(rand_pixel());
    end

    drain();
    repeat (10) @(posedge clk);
    @(negedge clk);
    $display("converted %0d pixels: every hue sector and edge, zero and full saturation,",
             n_checked);
    $display("out-of-range fields clamped, with random stalls on both sides");
    if (n_fail == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #500000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsv_pkg.sv
hw/rtl/hsv_ifs.sv
hw/rtl/hsv_scale.sv
hw/rtl/hsv_to_rgb_converter_top.sv
dv/hsv_rgb_checker.sv
dv/testbench.sv
